[rtl/l2st_pkg.sv]
// ----------------------------------------------------------------------------
// l2st_pkg
// Shared types and constants for the signalling channel table.
// ----------------------------------------------------------------------------
package l2st_pkg;

    localparam int CHANNELS    = 8;
    localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    localparam logic [1:0]  F_RX    = 2'd0;
    localparam logic [1:0]  F_CONN  = 2'd1;
    localparam logic [1:0]  F_CLEAR = 2'd2;

    localparam logic [15:0] CID_SIG      = 16'h0001;
    localparam logic [15:0] CID_FIRST    = 16'h0040;
    localparam logic [7:0]  IDENT_FIRST  = 8'h01;
    localparam logic [15:0] PSM_HID_CTRL = 16'h0011;
    localparam logic [15:0] PSM_HID_INTR = 16'h0013;
    localparam logic [15:0] INFO_EXT_FEAT = 16'h0002;
    localparam logic [15:0] INFO_NOTSUP  = 16'h0001;
    localparam logic [15:0] MIN_LEN      = 16'd8;
    localparam logic [15:0] MIN_SIG_LEN  = 16'd12;

    localparam logic [7:0]  C_CONN_REQ = 8'h02;
    localparam logic [7:0]  C_CONN_RSP = 8'h03;
    localparam logic [7:0]  C_CFG_REQ  = 8'h04;
    localparam logic [7:0]  C_CFG_RSP  = 8'h05;
    localparam logic [7:0]  C_INFO_REQ = 8'h0A;
    localparam logic [7:0]  C_INFO_RSP = 8'h0B;

    localparam logic [15:0] RES_OK      = 16'd0;
    localparam logic [15:0] RES_PENDING = 16'd1;

    typedef enum logic [1:0] {
        M_LOCAL,
        M_PSM,
        M_FREE,
        M_WAIT
    } t_mode;

    typedef struct packed {
        logic [15:0] lcid;
        logic [15:0] rcid;
        logic [15:0] psm;
        logic        open;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic ctrl;
        logic intr;
    } t_match;

    typedef struct packed {
        logic [7:0]  code;
        logic [7:0]  ident;
        logic [3:0]  len;
        logic [15:0] w0;
        logic [15:0] w1;
    } t_frame;

endpackage

[rtl/l2st_match.sv]
// ----------------------------------------------------------------------------
// l2st_match
// Shared compare unit: tests one table entry against the active search.
// ----------------------------------------------------------------------------
module l2st_match
    import l2st_pkg::*;
(
    input  t_mode       i_mode,
    input  logic [15:0] i_key,
    input  t_entry      i_ent,
    output t_match      o_match
);

    logic used;

    assign used = (i_ent.lcid != 16'd0);

    always_comb begin
        case (i_mode)
            M_LOCAL: o_match.hit = (i_key != 16'd0) && (i_ent.lcid == i_key);
            M_PSM:   o_match.hit = used && (i_ent.psm == i_key);
            M_FREE:  o_match.hit = !used;
            M_WAIT:  o_match.hit = used && (i_ent.rcid != 16'd0) && !i_ent.open;
            default: o_match.hit = 1'b0;
        endcase
        o_match.ctrl = i_ent.open && (i_ent.psm == PSM_HID_CTRL);
        o_match.intr = i_ent.open && (i_ent.psm == PSM_HID_INTR);
    end

endmodule

[rtl/l2cap_signalling_channel_table.sv]
// ----------------------------------------------------------------------------
// l2cap_signalling_channel_table
// L2CAP signalling endpoint with a small channel table.
//
// Usage:
//   Slave channel: one transfer carries a received ACL frame header with its
//   signalling fields, a local connect request, or a table clear (tuser).
//   Master channel: each input item yields one or more result transfers, the
//   final one marked by tlast. tuser flags a result that carries a
//   signalling frame; tdata holds the frame and the HID channel status.
//   i_cfg_we/i_cfg_wdata write the link handle; write only while idle.
// Sequence:
//   The table is walked one entry per cycle through a single compare unit.
//   After acceptance: a decode state, up to two lookup walks that stop at a
//   hit plus an action state (both walks only for a connection request that
//   misses its PSM), or one walk over all entries for the waiting channels
//   of an info response, or neither, then a status walk over all entries
//   and a load state. Each later result passes through the load state after
//   the previous transfer, and, when replying to an info response, through
//   a seek state for every entry passed. The block returns to idle in the
//   cycle after the final transfer. o_s_axis_tready is high only when idle.
// Reset: clears the table, next CID 0x0040, next identifier 1, link 0.
// Stalls: hold a result in the output register until taken; the block waits.
// ----------------------------------------------------------------------------
module l2cap_signalling_channel_table
    import l2st_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [11:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // rx_handle, rx_len, rx_cid, sig_code, sig_ident, rx_word0..2, zero pad
    input  logic [111:0] i_s_axis_tdata,
    // func
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tx_code, tx_ident, tx_len, tx_word0, tx_word1, hid_deliver, ctrl_open,
    // ctrl_remote_cid, intr_open, intr_remote_cid, zero pad
    output logic [87:0]  o_m_axis_tdata,
    // tx_valid
    output logic [0:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SCAN, S_ACT, S_SERVE, S_STAT, S_LOAD, S_SEEK, S_HOLD
    } t_state;

    t_state            r_state, n_state;
    logic [11:0]       r_link, n_link;
    logic [1:0]        r_func, n_func;
    logic [11:0]       r_handle, n_handle;
    logic [15:0]       r_len, n_len, r_cid, n_cid;
    logic [7:0]        r_code, n_code, r_ident, n_ident;
    logic [15:0]       r_w0, n_w0, r_w1, n_w1, r_w2, n_w2;
    logic [15:0]       r_local  [CHANNELS], n_local  [CHANNELS];
    logic [15:0]       r_remote [CHANNELS], n_remote [CHANNELS];
    logic [15:0]       r_psm    [CHANNELS], n_psm    [CHANNELS];
    logic [CHANNELS-1:0] r_open, n_open, r_mask, n_mask;
    logic [15:0]       r_next_cid, n_next_cid;
    logic [7:0]        r_next_ident, n_next_ident, r_srv_base, n_srv_base;
    t_mode             r_mode, n_mode;
    logic [15:0]       r_key, n_key;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_found, n_found, r_deliver, n_deliver;
    t_frame            r_f0, n_f0, r_f1, n_f1, r_out, n_out;
    logic              r_out_tx, n_out_tx, r_out_hid, n_out_hid;
    logic [CNT_W-1:0]  r_nfix, n_nfix, r_srv, n_srv, r_ntot, n_ntot, r_k, n_k;
    logic              r_cc_open, n_cc_open, r_ci_open, n_ci_open;
    logic [15:0]       r_cc_cid, n_cc_cid, r_ci_cid, n_ci_cid;

    t_entry            w_ent;
    t_match            w_m;
    logic              w_last_idx, w_link_up, w_last;
    logic [15:0]       w_loc;

    assign w_ent.lcid = r_local[r_idx];
    assign w_ent.rcid = r_remote[r_idx];
    assign w_ent.psm  = r_psm[r_idx];
    assign w_ent.open = r_open[r_idx];

    l2st_match u_match (
        .i_mode  (r_mode),
        .i_key   (r_key),
        .i_ent   (w_ent),
        .o_match (w_m)
    );

    assign w_last_idx = (r_idx == IDX_W'(CHANNELS - 1));
    assign w_link_up  = (r_link != 12'd0);
    assign w_last     = (r_ntot == '0) || (r_k == CNT_W'(r_ntot - 1'b1));

    always_comb begin
        n_state = r_state;   n_link = r_link;     n_func = r_func;
        n_handle = r_handle; n_len = r_len;       n_cid = r_cid;
        n_code = r_code;     n_ident = r_ident;
        n_w0 = r_w0;         n_w1 = r_w1;         n_w2 = r_w2;
        n_local = r_local;   n_remote = r_remote; n_psm = r_psm;
        n_open = r_open;     n_mask = r_mask;
        n_next_cid = r_next_cid; n_next_ident = r_next_ident;
        n_srv_base = r_srv_base;
        n_mode = r_mode;     n_key = r_key;       n_idx = r_idx;
        n_found = r_found;   n_deliver = r_deliver;
        n_f0 = r_f0;         n_f1 = r_f1;         n_out = r_out;
        n_out_tx = r_out_tx; n_out_hid = r_out_hid;
        n_nfix = r_nfix;     n_srv = r_srv;       n_ntot = r_ntot;  n_k = r_k;
        n_cc_open = r_cc_open; n_ci_open = r_ci_open;
        n_cc_cid = r_cc_cid;   n_ci_cid = r_ci_cid;
        w_loc = r_next_cid;

        if (i_cfg_we) begin
            n_link = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_func   = i_s_axis_tuser;
                    n_handle = i_s_axis_tdata[11:0];
                    n_len    = i_s_axis_tdata[27:12];
                    n_cid    = i_s_axis_tdata[43:28];
                    n_code   = i_s_axis_tdata[51:44];
                    n_ident  = i_s_axis_tdata[59:52];
                    n_w0     = i_s_axis_tdata[75:60];
                    n_w1     = i_s_axis_tdata[91:76];
                    n_w2     = i_s_axis_tdata[107:92];
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_idx = '0;       n_found = 1'b0;   n_deliver = 1'b0;
                n_nfix = '0;      n_srv = '0;       n_mask = '0;
                n_cc_open = 1'b0; n_ci_open = 1'b0;
                n_cc_cid = '0;    n_ci_cid = '0;
                n_state = S_STAT;
                if (r_func == F_RX) begin
                    if (r_len >= MIN_LEN && r_handle == r_link) begin
                        if (r_cid == CID_SIG) begin
                            if (r_len >= MIN_SIG_LEN) begin
                                case (r_code)
                                    C_CONN_REQ: begin
                                        n_mode = M_PSM;   n_key = r_w0;
                                        n_state = S_SCAN;
                                    end
                                    C_CONN_RSP: begin
                                        n_mode = M_LOCAL; n_key = r_w1;
                                        n_state = S_SCAN;
                                    end
                                    C_CFG_REQ, C_CFG_RSP: begin
                                        n_mode = M_LOCAL; n_key = r_w0;
                                        n_state = S_SCAN;
                                    end
                                    C_INFO_REQ: begin
                                        n_f0 = '{C_INFO_RSP, r_ident, 4'd4, r_w0,
                                                 INFO_NOTSUP};
                                        n_nfix = w_link_up ? CNT_W'(1) : '0;
                                    end
                                    C_INFO_RSP: begin
                                        n_mode = M_WAIT;
                                        n_srv_base = r_next_ident;
                                        n_state = S_SERVE;
                                    end
                                    default: n_state = S_STAT;
                                endcase
                            end
                        end else begin
                            n_mode = M_LOCAL; n_key = r_cid;
                            n_state = S_SCAN;
                        end
                    end
                end else if (r_func == F_CONN) begin
                    n_mode = M_FREE;
                    n_state = S_SCAN;
                end else if (r_func == F_CLEAR) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        n_local[i] = '0; n_remote[i] = '0; n_psm[i] = '0;
                    end
                    n_open = '0;
                    n_next_cid = CID_FIRST;
                    n_next_ident = IDENT_FIRST;
                end
            end
            S_SCAN: begin
                // stop on a hit with the index held; a PSM search falls back to a free entry
                if (w_m.hit) begin
                    n_found = 1'b1;
                    n_state = S_ACT;
                end else if (w_last_idx) begin
                    n_idx = '0;
                    if (r_mode == M_PSM) begin
                        n_mode = M_FREE;
                    end else begin
                        n_state = S_ACT;
                    end
                end else begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            S_ACT: begin
                n_state = S_STAT;
                n_idx = '0;
                if (r_found) begin
                    if (r_func == F_CONN) begin
                        n_local[r_idx] = r_next_cid;
                        n_psm[r_idx] = r_w0;
                        n_open[r_idx] = 1'b0;
                        n_next_cid = r_next_cid + 16'd1;
                        n_f0 = '{C_CONN_REQ, r_next_ident, 4'd4, r_w0, r_next_cid};
                        n_next_ident = r_next_ident + 8'd1;
                        n_nfix = w_link_up ? CNT_W'(1) : '0;
                    end else if (r_cid != CID_SIG) begin
                        n_deliver = (w_ent.psm == PSM_HID_INTR);
                    end else begin
                        case (r_code)
                            C_CONN_REQ: begin
                                if (r_mode == M_FREE) begin
                                    n_local[r_idx] = r_next_cid;
                                    n_psm[r_idx] = r_w0;
                                    n_open[r_idx] = 1'b0;
                                    n_next_cid = r_next_cid + 16'd1;
                                end else begin
                                    w_loc = w_ent.lcid;
                                end
                                n_remote[r_idx] = r_w1;
                                n_f0 = '{C_CONN_RSP, r_ident, 4'd8, w_loc, r_w1};
                                n_f1 = '{C_CFG_REQ, r_next_ident, 4'd4, r_w1, 16'd0};
                                n_next_ident = r_next_ident + 8'd1;
                                n_nfix = w_link_up ? CNT_W'(2) : '0;
                            end
                            C_CONN_RSP: begin
                                if (r_w2 == RES_OK) begin
                                    n_remote[r_idx] = r_w0;
                                    n_f0 = '{C_CFG_REQ, r_next_ident, 4'd4, r_w0, 16'd0};
                                    n_next_ident = r_next_ident + 8'd1;
                                    n_nfix = w_link_up ? CNT_W'(1) : '0;
                                end else if (r_w2 == RES_PENDING) begin
                                    n_remote[r_idx] = r_w0;
                                    n_f0 = '{C_INFO_REQ, r_next_ident, 4'd2, INFO_EXT_FEAT,
                                             16'd0};
                                    n_next_ident = r_next_ident + 8'd1;
                                    n_nfix = w_link_up ? CNT_W'(1) : '0;
                                end
                            end
                            C_CFG_REQ: begin
                                n_f0 = '{C_CFG_RSP, r_ident, 4'd6, w_ent.rcid,
                                         16'd0};
                                n_open[r_idx] = 1'b1;
                                n_nfix = w_link_up ? CNT_W'(1) : '0;
                            end
                            C_CFG_RSP: begin
                                if (r_w2 == RES_OK) begin
                                    n_open[r_idx] = 1'b1;
                                end
                            end
                            default: n_state = S_STAT;
                        endcase
                    end
                end
            end
            S_SERVE: begin
                // take an identifier per waiting channel, up to MAX_RESULTS; mark it for sending if the link is up
                if (w_m.hit && r_srv < CNT_W'(MAX_RESULTS)) begin
                    n_next_ident = r_next_ident + 8'd1;
                    n_srv = r_srv + 1'b1;
                    if (w_link_up) begin
                        n_mask[r_idx] = 1'b1;
                    end
                end
                if (w_last_idx) begin
                    n_idx = '0;
                    n_state = S_STAT;
                end else begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            S_STAT: begin
                if (w_m.ctrl && !r_cc_open) begin
                    n_cc_open = 1'b1;
                    n_cc_cid = w_ent.rcid;
                end
                if (w_m.intr && !r_ci_open) begin
                    n_ci_open = 1'b1;
                    n_ci_cid = w_ent.rcid;
                end
                if (w_last_idx) begin
                    n_idx = '0;
                    n_k = '0;
                    n_ntot = r_nfix + (w_link_up ? r_srv : CNT_W'(0));
                    n_state = S_LOAD;
                end else begin
                    n_idx = IDX_W'(r_idx + 1'b1);
                end
            end
            S_LOAD: begin
                if (r_ntot == '0) begin
                    n_out = '0;
                    n_out_tx = 1'b0;
                    n_out_hid = r_deliver;
                    n_state = S_HOLD;
                end else if (r_k < r_nfix) begin
                    n_out = (r_k == '0) ? r_f0 : r_f1;
                    n_out_tx = 1'b1;
                    n_out_hid = 1'b0;
                    n_state = S_HOLD;
                end else begin
                    n_state = S_SEEK;
                end
            end
            S_SEEK: begin
                if (r_mask[r_idx]) begin
                    n_out = '{C_CFG_REQ, r_srv_base + 8'(r_k), 4'd4,
                              w_ent.rcid, 16'd0};
                    n_out_tx = 1'b1;
                    n_out_hid = 1'b0;
                    n_state = S_HOLD;
                end
                n_idx = IDX_W'(r_idx + 1'b1);
            end
            S_HOLD: begin
                if (i_m_axis_tready) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_link <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_local[i] <= '0; r_remote[i] <= '0; r_psm[i] <= '0;
            end
            r_open <= '0;       r_mask <= '0;
            r_next_cid <= CID_FIRST;
            r_next_ident <= IDENT_FIRST;
            r_mode <= M_LOCAL;  r_idx <= '0;
            r_found <= 1'b0;    r_deliver <= 1'b0;
            r_nfix <= '0;       r_srv <= '0;  r_ntot <= '0;  r_k <= '0;
            r_cc_open <= 1'b0;  r_ci_open <= 1'b0;
        end else begin
            r_state <= n_state;
            r_link <= n_link;
            r_local <= n_local; r_remote <= n_remote; r_psm <= n_psm;
            r_open <= n_open;   r_mask <= n_mask;
            r_next_cid <= n_next_cid;
            r_next_ident <= n_next_ident;
            r_mode <= n_mode;   r_idx <= n_idx;
            r_found <= n_found; r_deliver <= n_deliver;
            r_nfix <= n_nfix;   r_srv <= n_srv;  r_ntot <= n_ntot;  r_k <= n_k;
            r_cc_open <= n_cc_open; r_ci_open <= n_ci_open;
        end
        // payload registers: no reset needed
        r_func <= n_func;   r_handle <= n_handle; r_len <= n_len;  r_cid <= n_cid;
        r_code <= n_code;   r_ident <= n_ident;
        r_w0 <= n_w0;       r_w1 <= n_w1;         r_w2 <= n_w2;
        r_srv_base <= n_srv_base; r_key <= n_key;
        r_f0 <= n_f0;       r_f1 <= n_f1;         r_out <= n_out;
        r_out_tx <= n_out_tx; r_out_hid <= n_out_hid;
        r_cc_cid <= n_cc_cid; r_ci_cid <= n_ci_cid;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_HOLD);
    assign o_m_axis_tlast  = w_last;
    assign o_m_axis_tuser  = r_out_tx;
    assign o_m_axis_tdata  = {1'b0, r_ci_cid, r_ci_open, r_cc_cid, r_cc_open,
                              r_out_hid, r_out.w1, r_out.w0, r_out.len,
                              r_out.ident, r_out.code};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while a result is pending");

    a_hid_only_without_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> !o_m_axis_tdata[52])
        else $error("delivery flag on a result carrying a frame");

    a_served_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_srv <= CNT_W'(MAX_RESULTS))
        else $error("too many info response replies");

    a_link_down_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_link == 12'd0) |-> !o_m_axis_tuser[0])
        else $error("frame sent with link down");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(r_k)))
        else $error("result dropped under stall");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for l2cap_signalling_channel_table: a directed table of
// signalling sequences, then random traffic biased toward well-formed
// connection, configuration and info exchanges. A behavioral model of the
// channel table predicts every result transfer; results are compared field
// by field in order. Both stream sides idle at random until the last phase.
// ----------------------------------------------------------------------------
module tb;
    import l2st_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct {
        logic [1:0]  fn;
        logic [11:0] hdl;
        logic [15:0] len;
        logic [15:0] cid;
        logic [7:0]  code;
        logic [7:0]  ident;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
    } t_item;

    typedef struct {
        logic        txv;
        t_frame      fr;
        logic        hid;
        logic        c_open;
        logic [15:0] c_cid;
        logic        i_open;
        logic [15:0] i_cid;
        logic        last;
    } t_result;

    typedef struct {
        t_item   it;
        bit      typed;   // expected result typed in below, single zero result
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [11:0]  i_cfg_wdata = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // rx_handle, rx_len, rx_cid, sig_code, sig_ident, rx_word0..2, zero pad
    logic [111:0] i_s_axis_tdata = '0;
    // func
    logic [1:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // tx_code, tx_ident, tx_len, tx_word0, tx_word1, hid_deliver, ctrl_open,
    // ctrl_remote_cid, intr_open, intr_remote_cid, zero pad
    logic [87:0]  o_m_axis_tdata;
    // tx_valid
    logic [0:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;

    l2cap_signalling_channel_table DUT (.*);

    always #1 i_clk = ~i_clk;

    // ---- channel table model ----
    logic [15:0] tbl_lcid [CHANNELS];
    logic [15:0] tbl_rcid [CHANNELS];
    logic [15:0] tbl_psm  [CHANNELS];
    bit          tbl_open [CHANNELS];
    logic [15:0] cid_next;
    logic [7:0]  ident_next;
    logic [11:0] link_hdl;

    t_result pending_q[$];   // result transfers still owed by the block
    int      errors = 0;
    int      cycles = 0;
    int      send_idle_pct = 15;
    int      recv_idle_pct = 70;

    task automatic table_clear();
        for (int i = 0; i < CHANNELS; i++) begin
            tbl_lcid[i] = '0;
            tbl_rcid[i] = '0;
            tbl_psm[i]  = '0;
            tbl_open[i] = 1'b0;
        end
        cid_next   = CID_FIRST;
        ident_next = IDENT_FIRST;
    endtask

    function automatic int lookup_local(logic [15:0] c);
        if (c == 16'd0) return -1;
        for (int i = 0; i < CHANNELS; i++)
            if (tbl_lcid[i] == c) return i;
        return -1;
    endfunction

    function automatic int lookup_psm(logic [15:0] p);
        for (int i = 0; i < CHANNELS; i++)
            if (tbl_lcid[i] != 16'd0 && tbl_psm[i] == p) return i;
        return -1;
    endfunction

    function automatic int open_by_psm(logic [15:0] p);
        for (int i = 0; i < CHANNELS; i++)
            if (tbl_psm[i] == p && tbl_open[i]) return i;
        return -1;
    endfunction

    task automatic alloc_chan(input logic [15:0] p, output int e);
        e = -1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (tbl_lcid[i] == 16'd0) begin
                tbl_lcid[i] = cid_next;
                cid_next    = cid_next + 16'd1;
                tbl_psm[i]  = p;
                tbl_open[i] = 1'b0;
                e = i;
                break;
            end
        end
    endtask

    task automatic queue_frame(ref t_frame fq[$], input logic [7:0] c, input logic [7:0] id,
                               input logic [3:0] l, input logic [15:0] a, input logic [15:0] b);
        t_frame f;
        if (link_hdl == 12'd0 || fq.size() >= MAX_RESULTS) return;
        f.code = c; f.ident = id; f.len = l; f.w0 = a; f.w1 = b;
        fq.push_back(f);
    endtask

    function automatic logic [7:0] grab_ident();
        logic [7:0] v;
        v = ident_next;
        ident_next = ident_next + 8'd1;
        return v;
    endfunction

    task automatic run_signalling(const ref t_item it, ref t_frame fq[$]);
        int e;
        int served;
        case (it.code)
            C_CONN_REQ: begin
                e = lookup_psm(it.w0);
                if (e < 0) alloc_chan(it.w0, e);
                if (e >= 0) begin
                    tbl_rcid[e] = it.w1;
                    queue_frame(fq, C_CONN_RSP, it.ident, 4'd8, tbl_lcid[e], it.w1);
                    queue_frame(fq, C_CFG_REQ, grab_ident(), 4'd4, tbl_rcid[e], 16'd0);
                end
            end
            C_CONN_RSP: begin
                e = lookup_local(it.w1);
                if (e >= 0) begin
                    if (it.w2 == RES_OK) begin
                        tbl_rcid[e] = it.w0;
                        queue_frame(fq, C_CFG_REQ, grab_ident(), 4'd4, it.w0, 16'd0);
                    end else if (it.w2 == RES_PENDING) begin
                        tbl_rcid[e] = it.w0;
                        queue_frame(fq, C_INFO_REQ, grab_ident(), 4'd2, INFO_EXT_FEAT, 16'd0);
                    end
                end
            end
            C_CFG_REQ: begin
                e = lookup_local(it.w0);
                if (e >= 0) begin
                    queue_frame(fq, C_CFG_RSP, it.ident, 4'd6, tbl_rcid[e], 16'd0);
                    tbl_open[e] = 1'b1;
                end
            end
            C_CFG_RSP: begin
                e = lookup_local(it.w0);
                if (e >= 0 && it.w2 == 16'd0) tbl_open[e] = 1'b1;
            end
            C_INFO_REQ: queue_frame(fq, C_INFO_RSP, it.ident, 4'd4, it.w0, INFO_NOTSUP);
            C_INFO_RSP: begin
                served = 0;
                for (int i = 0; i < CHANNELS && served < MAX_RESULTS; i++) begin
                    if (tbl_lcid[i] != 0 && tbl_rcid[i] != 0 && !tbl_open[i]) begin
                        queue_frame(fq, C_CFG_REQ, grab_ident(), 4'd4, tbl_rcid[i], 16'd0);
                        served++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Advance the model by one accepted item and append its result transfers.
    task automatic predict_item(const ref t_item it);
        t_frame  fq[$];
        t_result r;
        logic    deliver;
        int      e;
        int      cc;
        int      ci;
        int      n;
        deliver = 1'b0;
        if (it.fn == F_RX) begin
            if (it.len >= MIN_LEN && it.hdl == link_hdl) begin
                if (it.cid == CID_SIG) begin
                    if (it.len >= MIN_SIG_LEN) run_signalling(it, fq);
                end else begin
                    e = lookup_local(it.cid);
                    if (e >= 0 && tbl_psm[e] == PSM_HID_INTR) deliver = 1'b1;
                end
            end
        end else if (it.fn == F_CONN) begin
            alloc_chan(it.w0, e);
            if (e >= 0) queue_frame(fq, C_CONN_REQ, grab_ident(), 4'd4, it.w0, tbl_lcid[e]);
        end else if (it.fn == F_CLEAR) begin
            table_clear();
        end
        cc = open_by_psm(PSM_HID_CTRL);
        ci = open_by_psm(PSM_HID_INTR);
        r.c_open = (cc >= 0);
        r.c_cid  = (cc >= 0) ? tbl_rcid[cc] : 16'd0;
        r.i_open = (ci >= 0);
        r.i_cid  = (ci >= 0) ? tbl_rcid[ci] : 16'd0;
        n = (fq.size() == 0) ? 1 : fq.size();
        for (int k = 0; k < n; k++) begin
            r.txv  = (fq.size() != 0);
            r.fr   = (fq.size() != 0) ? fq[k] : '0;
            r.hid  = (fq.size() == 0) ? deliver : 1'b0;
            r.last = (k == n - 1);
            pending_q.push_back(r);
        end
    endtask

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_result a;
        t_result x;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            a.fr     = {o_m_axis_tdata[7:0], o_m_axis_tdata[15:8], o_m_axis_tdata[19:16],
                        o_m_axis_tdata[35:20], o_m_axis_tdata[51:36]};
            a.hid    = o_m_axis_tdata[52];
            a.c_open = o_m_axis_tdata[53];
            a.c_cid  = o_m_axis_tdata[69:54];
            a.i_open = o_m_axis_tdata[70];
            a.i_cid  = o_m_axis_tdata[86:71];
            a.txv    = o_m_axis_tuser[0];
            a.last   = o_m_axis_tlast;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer tdata=%h", o_m_axis_tdata);
            end else begin
                x = pending_q.pop_front();
                if (a.txv !== x.txv || a.fr !== x.fr || a.hid !== x.hid
                    || a.c_open !== x.c_open || a.c_cid !== x.c_cid
                    || a.i_open !== x.i_open || a.i_cid !== x.i_cid || a.last !== x.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp txv=%0b frame=%h hid=%0b ctrl=%0b/%h ",
                                  "intr=%0b/%h last=%0b | got txv=%0b frame=%h hid=%0b ",
                                  "ctrl=%0b/%h intr=%0b/%h last=%0b"},
                                 x.txv, x.fr, x.hid, x.c_open, x.c_cid, x.i_open, x.i_cid,
                                 x.last, a.txv, a.fr, a.hid, a.c_open, a.c_cid, a.i_open,
                                 a.i_cid, a.last);
                end
            end
        end
        if (cycles > TIMEOUT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver backpressure, reshuffled every falling edge.
    always @(negedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // ---- stimulus ----
    function automatic t_item mk(logic [1:0] f, logic [11:0] h, logic [15:0] l, logic [15:0] c,
                                 logic [7:0] cd, logic [7:0] id, logic [15:0] a,
                                 logic [15:0] b, logic [15:0] d);
        t_item it;
        it.fn = f; it.hdl = h; it.len = l; it.cid = c; it.code = cd; it.ident = id;
        it.w0 = a; it.w1 = b; it.w2 = d;
        return it;
    endfunction

    // Drive one item and hold it until the transfer; update the model then.
    task automatic push_item(t_item it, bit typed);
        t_result z;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = it.fn;
        i_s_axis_tdata  = {4'd0, it.w2, it.w1, it.w0, it.ident, it.code, it.cid, it.len, it.hdl};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (typed) begin
            // zero result, status all clear: fresh table and nothing open
            z = '{txv: 1'b0, fr: '0, hid: 1'b0, c_open: 1'b0, c_cid: 16'd0,
                  i_open: 1'b0, i_cid: 16'd0, last: 1'b1};
            pending_q.push_back(z);
            if (it.fn == F_CONN) begin
                predict_item(it);
                void'(pending_q.pop_back());
            end
        end else begin
            predict_item(it);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Wait for the block to drain, then write the link handle.
    task automatic write_link(logic [11:0] v);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        link_hdl    = v;
    endtask

    function automatic logic [15:0] known_cid();
        int i;
        i = $urandom_range(CHANNELS - 1);
        if ($urandom_range(9) == 0) return 16'($urandom);
        return (tbl_lcid[i] != 0) ? tbl_lcid[i] : cid_next - 16'd1;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        logic [7:0] codes [6] = '{C_CONN_REQ, C_CONN_RSP, C_CFG_REQ, C_CFG_RSP,
                                  C_INFO_REQ, C_INFO_RSP};
        logic [15:0] psms [3] = '{PSM_HID_CTRL, PSM_HID_INTR, 16'h0001};
        it = mk(2'($urandom), 12'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        pick = $urandom_range(99);
        if (pick < 8) return it;                              // pure noise
        if (pick < 11) begin it.fn = F_CLEAR; return it; end
        if (pick < 25) begin
            it.fn = F_CONN;
            if ($urandom_range(3) != 0) it.w0 = psms[$urandom_range(2)];
            return it;
        end
        it.fn  = F_RX;
        it.hdl = ($urandom_range(19) == 0) ? 12'($urandom) : link_hdl;
        it.len = ($urandom_range(9) == 0) ? 16'($urandom_range(15))
                                          : 16'($urandom_range(12, 65535));
        if (pick < 35) begin
            it.cid = known_cid();                             // data frame
        end else begin
            it.cid  = CID_SIG;
            it.code = ($urandom_range(19) == 0) ? 8'($urandom) : codes[$urandom_range(5)];
            case (it.code)
                C_CONN_REQ: if ($urandom_range(2) != 0) it.w0 = psms[$urandom_range(2)];
                C_CONN_RSP: begin
                    it.w1 = known_cid();
                    it.w2 = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(1));
                end
                C_CFG_REQ: it.w0 = known_cid();
                C_CFG_RSP: begin
                    it.w0 = known_cid();
                    it.w2 = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0;
                end
                default: ;
            endcase
        end
        return it;
    endfunction

    t_row dir_rows[$];

    initial begin
        t_item it;
        table_clear();
        link_hdl = 12'd0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Link down: nothing is sent; the connect still takes a CID.
        dir_rows.push_back('{mk(2'd3, 12'hFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1});
        dir_rows.push_back('{mk(F_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1});
        dir_rows.push_back('{mk(F_RX, 0, 16'd7, CID_SIG, C_INFO_REQ, 8'h01, 0, 0, 0), 1'b1});
        dir_rows.push_back('{mk(F_CONN, 0, 0, 0, 0, 0, PSM_HID_CTRL, 0, 0), 1'b1});
        dir_rows.push_back('{mk(F_RX, 0, 16'd12, CID_SIG, C_INFO_REQ, 8'h07, 16'h0002, 0, 0),
                             1'b1});
        write_link(12'd0);
        foreach (dir_rows[i]) push_item(dir_rows[i].it, dir_rows[i].typed);
        dir_rows.delete();

        write_link(12'hABC);
        // Full control channel setup, pending interrupt channel, info flood.
        dir_rows.push_back('{mk(F_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_CONN, 0, 0, 0, 0, 0, PSM_HID_CTRL, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd12, CID_SIG, C_CONN_RSP, 8'h01,
                                16'h0070, 16'h0040, RES_OK), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd12, CID_SIG, C_CFG_REQ, 8'h22,
                                16'h0040, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd12, CID_SIG, C_CFG_RSP, 8'h03,
                                16'h0040, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_CONN, 0, 0, 0, 0, 0, PSM_HID_INTR, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'hFFFF, CID_SIG, C_CONN_RSP, 8'hFF,
                                16'hFFFF, 16'h0041, RES_PENDING), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd12, CID_SIG, C_INFO_REQ, 8'h00,
                                16'hFFFF, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd12, CID_SIG, C_INFO_RSP, 8'h09,
                                0, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd12, CID_SIG, C_CFG_REQ, 8'h10,
                                16'h0041, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd8, 16'h0041, 0, 0, 0, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABB, 16'd8, 16'h0041, 0, 0, 0, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd11, CID_SIG, C_INFO_REQ, 8'h05,
                                0, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd12, CID_SIG, 8'hFF, 8'h05, 0, 0, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd12, CID_SIG, C_CONN_REQ, 8'h44,
                                16'h0017, 16'h0080, 0), 1'b0});
        dir_rows.push_back('{mk(F_RX, 12'hABC, 16'd12, 16'h0000, 0, 0, 0, 0, 0), 1'b0});
        foreach (dir_rows[i]) push_item(dir_rows[i].it, dir_rows[i].typed);

        // Four random phases, each with its own link handle; the last has no idling.
        send_idle_pct = 15; recv_idle_pct = 70;
        for (int n = 0; n < 90; n++) begin it = random_item(); push_item(it, 0); end
        write_link(12'hFFF);
        send_idle_pct = 70; recv_idle_pct = 15;
        for (int n = 0; n < 60; n++) begin it = random_item(); push_item(it, 0); end
        write_link(12'h000);
        for (int n = 0; n < 25; n++) begin it = random_item(); push_item(it, 0); end
        write_link(12'h001);
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int n = 0; n < 65; n++) begin it = random_item(); push_item(it, 0); end

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

[files.f]
rtl/l2st_pkg.sv
rtl/l2st_match.sv
rtl/l2cap_signalling_channel_table.sv
tb/tb.sv
